// File: hw/rtl/false_color_level_map_assert.svh
// Assertion macros for the false color level map
`ifndef FALSE_COLOR_LEVEL_MAP_ASSERT_SVH
`define FALSE_COLOR_LEVEL_MAP_ASSERT_SVH

// check cons in the same cycle as ante
`define FCLM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fclm assertion failed");

// check cons in the cycle after ante
`define FCLM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fclm assertion failed");

`endif

// File: hw/rtl/fclm_pkg.sv
// Types, constants and divider step for the false color level map
`default_nettype none

package fclm_pkg;

  localparam int LEVEL_W    = 19;
  localparam int SPAN_W     = 20;
  localparam int DELTA_W    = 17;
  localparam int NUM_W      = 25;
  localparam int RGB_W      = 24;
  localparam int IN_TDATA_W = 24;
  localparam int CFG_IDX_W  = 4;
  localparam int SEG_BITS   = 4;
  localparam int QUO_BITS   = 8;
  localparam int SH_W       = 3;

  localparam int DIV5_SHIFT = 23;
  localparam logic [SPAN_W:0] DIV5_MUL = 21'd1677722;

  localparam int ST_ABS   = 0;
  localparam int ST_DELTA = 1;
  localparam int ST_SEG0  = 2;
  localparam int ST_FIX   = ST_SEG0 + SEG_BITS;
  localparam int ST_QUO0  = ST_FIX + 1;
  localparam int ST_OUT   = ST_QUO0 + QUO_BITS;
  localparam int NSTAGE   = ST_OUT + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_LEVEL = 4'd0,
    REG_MIN_LEVEL = 4'd1
  } reg_idx_e;

  typedef enum logic [SEG_BITS-1:0] {
    SEG_RED_YEL = 4'd0,
    SEG_YEL_GRN = 4'd1,
    SEG_GRN_CYN = 4'd2,
    SEG_CYN_BLU = 4'd3,
    SEG_BLU_MAG = 4'd4,
    SEG_TOP     = 4'd5,
    SEG_PASTEL0 = 4'd6,
    SEG_PASTEL1 = 4'd7,
    SEG_PASTEL2 = 4'd8,
    SEG_PASTEL3 = 4'd9
  } seg_e;

  typedef struct packed {
    logic [NUM_W-1:0] pr;
    logic             take;
  } div_step_t;

  typedef struct packed {
    logic [SPAN_W-1:0]   pr;
    logic [DELTA_W-1:0]  delta;
    logic [SEG_BITS-1:0] quo;
    logic                sat;
  } seg_t;

  typedef struct packed {
    seg_e                seg;
    logic [DELTA_W-1:0]  delta;
    logic [NUM_W-1:0]    pr_up;
    logic [NUM_W-1:0]    pr_half;
    logic [QUO_BITS-1:0] q_up;
    logic [QUO_BITS-1:0] q_half;
  } quo_t;

  function automatic div_step_t div_step(logic [NUM_W-1:0] pr, logic [DELTA_W-1:0] d,
                                         logic [SH_W-1:0] sh);
    logic [NUM_W-1:0] ds;
    div_step_t        res;
    ds = NUM_W'(d) << sh;
    if (pr >= ds) begin
      res.pr   = pr - ds;
      res.take = 1'b1;
    end else begin
      res.pr   = pr;
      res.take = 1'b0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/false_color_level_map.sv
// Top level: pipelined mapping of signed levels to 24-bit heat-map colors
// Each transaction passes the offset, delta, segment, fix-up, ramp and output stages in turn.
// Throughput: one transaction per cycle; the 4-step segment divider and the
// 8-step ramp dividers each retire one quotient bit per pipeline stage.
// A stalled master side holds the whole pipeline and drops s_axis_tready.
// Reset clears the stage valid bits and both level registers to 0.
`default_nettype none
`include "false_color_level_map_assert.svh"

module false_color_level_map (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  input  wire logic [fclm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [18:0] sample_level
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output      logic [fclm_pkg::RGB_W-1:0]        m_axis_tdata,  // [23:0] rgb_color
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [fclm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [fclm_pkg::LEVEL_W-1:0]      cfg_data_i
);

  localparam int LW = fclm_pkg::LEVEL_W;
  localparam int SW = fclm_pkg::SPAN_W;
  localparam int DW = fclm_pkg::DELTA_W;
  localparam int NW = fclm_pkg::NUM_W;
  localparam int SB = fclm_pkg::SEG_BITS;
  localparam int QB = fclm_pkg::QUO_BITS;
  localparam int NS = fclm_pkg::NSTAGE;

  logic [LW-1:0] max_level_q, min_level_q;
  logic [NS-1:0] vld_q;
  logic          en;

  logic [SW-1:0] offset_a_q, span_a_q, offset_a_d, span_a_d;
  logic [SW-1:0] offset_b_q;
  logic [DW-1:0] delta_b_q, delta_b_d;
  logic [2*SW:0] delta_prod;

  fclm_pkg::seg_t seg_src [SB];
  fclm_pkg::seg_t sd_d    [SB];
  fclm_pkg::seg_t sd_q    [SB];

  fclm_pkg::quo_t fix_d, fix_q;
  fclm_pkg::quo_t quo_src [QB];
  fclm_pkg::quo_t qd_d    [QB];
  fclm_pkg::quo_t qd_q    [QB];

  localparam int RGB_W_LOCAL = fclm_pkg::RGB_W;
  logic [RGB_W_LOCAL-1:0] rgb_d, rgb_q;

  assign cfg_ready_o   = 1'b1;
  assign en            = !vld_q[fclm_pkg::ST_OUT] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[fclm_pkg::ST_OUT];
  assign m_axis_tdata  = rgb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_level_q <= '0;
      min_level_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        fclm_pkg::REG_MAX_LEVEL: max_level_q <= cfg_data_i;
        fclm_pkg::REG_MIN_LEVEL: min_level_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], s_axis_tvalid};
    end
  end

  always_comb begin
    logic [SW-1:0] sdiff, mdiff;
    sdiff      = {s_axis_tdata[LW-1], s_axis_tdata[LW-1:0]} - {min_level_q[LW-1], min_level_q};
    mdiff      = {max_level_q[LW-1], max_level_q} - {min_level_q[LW-1], min_level_q};
    offset_a_d = sdiff[SW-1] ? SW'(-sdiff) : sdiff;
    span_a_d   = mdiff[SW-1] ? SW'(-mdiff) : mdiff;
  end

  assign delta_prod = (2*SW+1)'(span_a_q) * (2*SW+1)'(fclm_pkg::DIV5_MUL);
  assign delta_b_d  = delta_prod[fclm_pkg::DIV5_SHIFT +: DW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      offset_a_q <= offset_a_d;
      span_a_q   <= span_a_d;
      offset_b_q <= offset_a_q;
      delta_b_q  <= delta_b_d;
    end
  end

  always_comb begin
    seg_src[0].pr    = offset_b_q;
    seg_src[0].delta = delta_b_q;
    seg_src[0].quo   = '0;
    seg_src[0].sat   = (21'(offset_b_q)) >= ((21'(delta_b_q) << 3) + (21'(delta_b_q) << 1));
  end

  for (genvar k = 0; k < SB; k++) begin : g_seg
    fclm_pkg::div_step_t st;
    if (k > 0) begin : g_link
      assign seg_src[k] = sd_q[k-1];
    end
    assign st = fclm_pkg::div_step(NW'(seg_src[k].pr), seg_src[k].delta,
                                   fclm_pkg::SH_W'(SB - 1 - k));
    always_comb begin
      sd_d[k]       = seg_src[k];
      sd_d[k].pr    = st.pr[SW-1:0];
      sd_d[k].quo   = {seg_src[k].quo[SB-2:0], st.take};
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sd_q[k] <= sd_d[k];
      end
    end
  end

  always_comb begin
    logic [DW-1:0] rem;
    rem           = sd_q[SB-1].pr[DW-1:0];
    fix_d.seg     = fclm_pkg::seg_e'(sd_q[SB-1].quo);
    fix_d.delta   = sd_q[SB-1].delta;
    if (sd_q[SB-1].sat) begin
      fix_d.seg = fclm_pkg::SEG_PASTEL3;
      rem       = sd_q[SB-1].delta;
    end else if (sd_q[SB-1].quo == fclm_pkg::SEG_TOP) begin
      fix_d.seg = fclm_pkg::SEG_BLU_MAG;
      rem       = sd_q[SB-1].delta;
    end
    fix_d.pr_up   = (NW'(rem) << 8) - NW'(rem);
    fix_d.pr_half = NW'(rem) << 7;
    fix_d.q_up    = '0;
    fix_d.q_half  = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fix_q <= fix_d;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_quo
    fclm_pkg::div_step_t st_up, st_half;
    if (k == 0) begin : g_head
      assign quo_src[k] = fix_q;
    end else begin : g_link
      assign quo_src[k] = qd_q[k-1];
    end
    assign st_up   = fclm_pkg::div_step(quo_src[k].pr_up, quo_src[k].delta,
                                        fclm_pkg::SH_W'(QB - 1 - k));
    assign st_half = fclm_pkg::div_step(quo_src[k].pr_half, quo_src[k].delta,
                                        fclm_pkg::SH_W'(QB - 1 - k));
    always_comb begin
      qd_d[k]         = quo_src[k];
      qd_d[k].pr_up   = st_up.pr;
      qd_d[k].pr_half = st_half.pr;
      qd_d[k].q_up    = {quo_src[k].q_up[QB-2:0], st_up.take};
      qd_d[k].q_half  = {quo_src[k].q_half[QB-2:0], st_half.take};
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        qd_q[k] <= qd_d[k];
      end
    end
  end

  always_comb begin
    logic [7:0] up, down, pup, pdown;
    logic       c_up, c_half;
    logic [7:0] r, g, b;
    c_up   = |qd_q[QB-1].pr_up;
    c_half = |qd_q[QB-1].pr_half;
    up     = qd_q[QB-1].q_up;
    down   = 8'hff - up - {7'd0, c_up};
    pup    = qd_q[QB-1].q_half + 8'h80;
    pdown  = 8'h00 - qd_q[QB-1].q_half - {7'd0, c_half};
    case (qd_q[QB-1].seg)
      fclm_pkg::SEG_RED_YEL: begin r = 8'hff;  g = up;     b = 8'h00; end
      fclm_pkg::SEG_YEL_GRN: begin r = down;   g = 8'hff;  b = 8'h00; end
      fclm_pkg::SEG_GRN_CYN: begin r = 8'h00;  g = 8'hff;  b = up;    end
      fclm_pkg::SEG_CYN_BLU: begin r = 8'h00;  g = down;   b = 8'hff; end
      fclm_pkg::SEG_BLU_MAG: begin r = up;     g = 8'h00;  b = 8'hff; end
      fclm_pkg::SEG_PASTEL0: begin r = pdown;  g = 8'hff;  b = 8'h80; end
      fclm_pkg::SEG_PASTEL1: begin r = 8'h80;  g = 8'hff;  b = pup;   end
      fclm_pkg::SEG_PASTEL2: begin r = 8'h80;  g = pdown;  b = 8'hff; end
      default:               begin r = pup;    g = 8'h80;  b = 8'hff; end
    endcase
    rgb_d = (qd_q[QB-1].delta == '0) ? {8'hff, 8'h00, 8'h00} : {r, g, b};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rgb_q <= rgb_d;
    end
  end

  `FCLM_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_q[fclm_pkg::ST_ABS])
  `FCLM_ASSERT_NOW(a_seg_fixed, vld_q[fclm_pkg::ST_FIX], fix_q.seg <= fclm_pkg::SEG_PASTEL3)
  `FCLM_ASSERT_NOW(a_ramp_rem_bound,
                   vld_q[fclm_pkg::ST_OUT - 1] && (qd_q[QB-1].delta != '0),
                   (qd_q[QB-1].pr_up < NW'(qd_q[QB-1].delta)) &&
                   (qd_q[QB-1].pr_half < NW'(qd_q[QB-1].delta)))

endmodule

`default_nettype wire
